[sv/mcr_pkg.sv]
// ----------------------------------------------------------------------------
// mcr_pkg
// shared constants, types and pixel arithmetic for the circle rasterizer
// ----------------------------------------------------------------------------
package mcr_pkg;

    localparam int COORD_BITS    = 10;
    localparam int PIXEL_BITS    = 12;
    localparam int COLOR_BITS    = 4;
    // offsets are signed and one step may leave y at -1
    localparam int OFF_BITS      = COORD_BITS + 2;
    // decision value stays within about +/- 4 * radius
    localparam int DEC_BITS      = COORD_BITS + 5;
    localparam int SUM_BITS      = (COORD_BITS + 1 > PIXEL_BITS) ? COORD_BITS + 1 : PIXEL_BITS;
    localparam int CFG_DATA_BITS = (COORD_BITS > COLOR_BITS) ? COORD_BITS : COLOR_BITS;
    localparam int CFG_IDX_BITS  = 2;
    localparam int QUEUE_DEPTH   = 2;
    localparam int QPTR_BITS     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_BITS     = $clog2(QUEUE_DEPTH + 1);
    localparam int PIX_PER_STEP  = 8;
    localparam int PIX_IDX_BITS  = $clog2(PIX_PER_STEP);

    localparam logic [COLOR_BITS-1:0] PEN_RESET = COLOR_BITS'(4);

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_CENTER_X  = 2'd0,
        CFG_CENTER_Y  = 2'd1,
        CFG_RADIUS_PX = 2'd2,
        CFG_PEN_COLOR = 2'd3
    } cfg_index_t;

    typedef logic [COORD_BITS-1:0] coord_t;
    typedef logic [COORD_BITS:0]   offset_t;
    typedef logic [COLOR_BITS-1:0] color_t;
    typedef logic [PIXEL_BITS-1:0] pixel_t;

    // one octant step handed from front to back
    typedef struct packed {
        offset_t x;
        offset_t y;
        logic    done;
    } step_t;

    // queue head as seen by the back end
    typedef struct packed {
        logic  valid;
        step_t step;
    } head_t;

    // center plus or minus offset, wrapped to the pixel width
    function automatic pixel_t pix_coord(coord_t c, offset_t o, logic neg);
        logic [SUM_BITS-1:0] s;
        s = neg ? (SUM_BITS'(c) - SUM_BITS'(o)) : (SUM_BITS'(c) + SUM_BITS'(o));
        return s[PIXEL_BITS-1:0];
    endfunction

endpackage

[sv/mcr_front.sv]
// ----------------------------------------------------------------------------
// mcr_front
// accepts step requests, runs the midpoint recurrence, queues drawing steps
// ----------------------------------------------------------------------------
module mcr_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    input  logic            restart,
    input  mcr_pkg::coord_t radius_px,
    output logic            push,
    output mcr_pkg::step_t  push_step,
    input  logic            queue_full
);
    import mcr_pkg::*;

    logic signed [OFF_BITS-1:0] off_x_reg, off_x_next;
    logic signed [OFF_BITS-1:0] off_y_reg, off_y_next;
    logic signed [DEC_BITS-1:0] dec_reg, dec_next;
    logic                       drawing_reg, drawing_next;

    logic                       accept;
    logic                       drawing_eff;
    logic                       emit;
    logic                       done;
    logic signed [OFF_BITS-1:0] x_eff, y_eff, x_upd, y_upd;
    logic signed [DEC_BITS-1:0] d_eff, d_upd, x_ext, y_ext;

    assign in_stall = queue_full;
    assign accept   = in_valid & ~queue_full;

    always_comb
    begin
        // restart reloads from the radius register
        x_eff       = restart ? '0 : off_x_reg;
        y_eff       = restart ? OFF_BITS'(radius_px) : off_y_reg;
        d_eff       = restart ? (DEC_BITS'(3) - (DEC_BITS'(radius_px) << 1)) : dec_reg;
        drawing_eff = restart | drawing_reg;
        emit        = drawing_eff && (x_eff <= y_eff);

        x_ext = DEC_BITS'(x_eff);
        y_ext = DEC_BITS'(y_eff);
        x_upd = x_eff + OFF_BITS'(1);
        if (d_eff[DEC_BITS-1])
        begin
            d_upd = d_eff + (x_ext <<< 2) + DEC_BITS'(6);
            y_upd = y_eff;
        end
        else
        begin
            d_upd = d_eff + ((x_ext - y_ext) <<< 2) + DEC_BITS'(10);
            y_upd = y_eff - OFF_BITS'(1);
        end
        done = x_upd > y_upd;

        off_x_next   = off_x_reg;
        off_y_next   = off_y_reg;
        dec_next     = dec_reg;
        drawing_next = drawing_reg;
        if (accept)
        begin
            if (emit)
            begin
                off_x_next   = x_upd;
                off_y_next   = y_upd;
                dec_next     = d_upd;
                drawing_next = ~done;
            end
            else
            begin
                off_x_next   = x_eff;
                off_y_next   = y_eff;
                dec_next     = d_eff;
                drawing_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            off_x_reg   <= '0;
            off_y_reg   <= '0;
            dec_reg     <= '0;
            drawing_reg <= 1'b0;
        end
        else
        begin
            off_x_reg   <= off_x_next;
            off_y_reg   <= off_y_next;
            dec_reg     <= dec_next;
            drawing_reg <= drawing_next;
        end
    end

    assign push           = accept & emit;
    assign push_step.x    = x_eff[COORD_BITS:0];
    assign push_step.y    = y_eff[COORD_BITS:0];
    assign push_step.done = done;

endmodule

[sv/mcr_queue.sv]
// ----------------------------------------------------------------------------
// mcr_queue
// short step queue between the recurrence front and the pixel back end
// ----------------------------------------------------------------------------
module mcr_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  mcr_pkg::step_t push_step,
    output logic           full,
    output mcr_pkg::head_t head,
    input  logic           pop
);
    import mcr_pkg::*;

    step_t                mem_reg [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_BITS-1:0] count_reg, count_next;

    function automatic logic [QPTR_BITS-1:0] ptr_inc(logic [QPTR_BITS-1:0] p);
        return (p == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_BITS'(1);
    endfunction

    assign full       = (count_reg == QCNT_BITS'(QUEUE_DEPTH));
    assign head.valid = (count_reg != '0);
    assign head.step  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + QCNT_BITS'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - QCNT_BITS'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_step;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("step pushed into a full queue");

    a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head.valid)
        else $error("step popped from an empty queue");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCNT_BITS'(QUEUE_DEPTH))
        else $error("queue count beyond depth");

    a_count_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (count_reg == $past(count_reg) + QCNT_BITS'(1)))
        else $error("queue count did not follow a push");

endmodule

[sv/mcr_back.sv]
// ----------------------------------------------------------------------------
// mcr_back
// expands each queued step into eight mirrored pixels, one per cycle unless out_stall holds them
// ----------------------------------------------------------------------------
module mcr_back (
    input  logic            clk,
    input  logic            rst_n,
    input  mcr_pkg::head_t  head,
    output logic            pop,
    input  mcr_pkg::coord_t center_x,
    input  mcr_pkg::coord_t center_y,
    input  mcr_pkg::color_t pen_color,
    output logic            out_valid,
    input  logic            out_stall,
    output mcr_pkg::pixel_t pixel_x,
    output mcr_pkg::pixel_t pixel_y,
    output mcr_pkg::color_t pixel_color,
    output logic            last_of_step,
    output logic            circle_done
);
    import mcr_pkg::*;

    logic [PIX_IDX_BITS-1:0] idx_reg, idx_next;
    logic                    out_valid_reg, out_valid_next;
    pixel_t                  pixel_x_reg, pixel_x_next;
    pixel_t                  pixel_y_reg, pixel_y_next;
    color_t                  color_reg, color_next;
    logic                    last_reg, last_next;
    logic                    done_reg, done_next;

    logic                    load;
    logic                    is_last;
    offset_t                 off_a, off_b;

    assign load    = ~out_valid_reg | ~out_stall;
    assign is_last = (idx_reg == PIX_IDX_BITS'(PIX_PER_STEP - 1));
    assign pop     = load & head.valid & is_last;

    always_comb
    begin
        // upper half of the sequence swaps the roles of x and y
        off_a = idx_reg[2] ? head.step.y : head.step.x;
        off_b = idx_reg[2] ? head.step.x : head.step.y;

        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        pixel_x_next   = pixel_x_reg;
        pixel_y_next   = pixel_y_reg;
        color_next     = color_reg;
        last_next      = last_reg;
        done_next      = done_reg;
        if (load)
        begin
            out_valid_next = head.valid;
            if (head.valid)
            begin
                idx_next     = idx_reg + PIX_IDX_BITS'(1);
                pixel_x_next = pix_coord(center_x, off_a, idx_reg[0]);
                pixel_y_next = pix_coord(center_y, off_b, ~idx_reg[1]);
                color_next   = pen_color;
                last_next    = is_last;
                done_next    = is_last & head.step.done;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pixel_x_reg <= pixel_x_next;
        pixel_y_reg <= pixel_y_next;
        color_reg   <= color_next;
        last_reg    <= last_next;
        done_reg    <= done_next;
    end

    assign out_valid    = out_valid_reg;
    assign pixel_x      = pixel_x_reg;
    assign pixel_y      = pixel_y_reg;
    assign pixel_color  = color_reg;
    assign last_of_step = last_reg;
    assign circle_done  = done_reg;

endmodule

[sv/midpoint_circle_rasterizer_top.sv]
// ----------------------------------------------------------------------------
// midpoint_circle_rasterizer_top
// eight-way symmetric midpoint circle generator with a step request interface
// ----------------------------------------------------------------------------
// each word on the input channel is one step request; restart=1 reloads the
// offsets from the radius register before stepping. a step that still lies
// in the first octant produces eight pixel words on the output channel, one
// per cycle unless out_stall holds them, the last one flagged last_of_step
// and, for the step that closes the circle, circle_done. a step on an idle or
// finished circle produces no words and skips the queue. the front end
// takes one request per cycle as long as its two-entry step queue has room;
// the single pixel port sets the sustained rate. a pixel passes through the
// step queue and the output register. center, radius and color must be
// written only while the block is idle; the block does not enforce this.
// ----------------------------------------------------------------------------
module midpoint_circle_rasterizer_top (
    input  logic                                clk,
    input  logic                                rst_n,
    // step request channel
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                restart,
    // pixel channel
    output logic                                out_valid,
    input  logic                                out_stall,
    output mcr_pkg::pixel_t                     pixel_x,
    output mcr_pkg::pixel_t                     pixel_y,
    output mcr_pkg::color_t                     pixel_color,
    output logic                                last_of_step,
    output logic                                circle_done,
    // configuration write channel
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [mcr_pkg::CFG_IDX_BITS-1:0]    cfg_index,
    input  logic [mcr_pkg::CFG_DATA_BITS-1:0]   cfg_data
);
    import mcr_pkg::*;

    coord_t center_x_reg;
    coord_t center_y_reg;
    coord_t radius_reg;
    color_t pen_color_reg;

    logic   cfg_write;
    logic   push;
    step_t  push_step;
    logic   queue_full;
    head_t  head;
    logic   pop;

    // configuration registers accept a write every cycle
    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid & cfg_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_x_reg  <= '0;
            center_y_reg  <= '0;
            radius_reg    <= '0;
            pen_color_reg <= PEN_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_CENTER_X:  center_x_reg  <= cfg_data[COORD_BITS-1:0];
                CFG_CENTER_Y:  center_y_reg  <= cfg_data[COORD_BITS-1:0];
                CFG_RADIUS_PX: radius_reg    <= cfg_data[COORD_BITS-1:0];
                CFG_PEN_COLOR: pen_color_reg <= cfg_data[COLOR_BITS-1:0];
                default:       ;
            endcase
        end
    end

    // recurrence: one request per cycle while the queue has room, drawing steps go to the queue
    mcr_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .restart    (restart),
        .radius_px  (radius_reg),
        .push       (push),
        .push_step  (push_step),
        .queue_full (queue_full)
    );

    // decouples request acceptance from pixel output back-pressure
    mcr_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_step (push_step),
        .full      (queue_full),
        .head      (head),
        .pop       (pop)
    );

    // mirror expansion into the registered pixel port
    mcr_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head),
        .pop          (pop),
        .center_x     (center_x_reg),
        .center_y     (center_y_reg),
        .pen_color    (pen_color_reg),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .pixel_x      (pixel_x),
        .pixel_y      (pixel_y),
        .pixel_color  (pixel_color),
        .last_of_step (last_of_step),
        .circle_done  (circle_done)
    );

endmodule
